// ===== rtl/rdc_pkg.sv =====
// Shared types, constants and helpers for the radix digit converter.
package rdc_pkg;

  localparam int BASE_W      = 4;
  localparam int IN_W        = 30;
  localparam int OUT_W       = 64;
  localparam int CHUNK       = 7;
  localparam int CHUNKS      = 5;
  localparam int VAL_W       = CHUNK * CHUNKS;
  localparam int CHUNK_CNT_W = 3;

  localparam logic [BASE_W-1:0] RADIX_TEN      = 4'd10;
  localparam logic [BASE_W-1:0] RADIX_MIN      = 4'd2;
  localparam logic [BASE_W-1:0] BASE_IN_RESET  = 4'd10;
  localparam logic [BASE_W-1:0] BASE_OUT_RESET = 4'd2;

  typedef enum logic {
    REG_BASE_IN  = 1'b0,
    REG_BASE_OUT = 1'b1
  } rdc_reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_IN,
    ST_ACC,
    ST_VAL,
    ST_DIV_OUT,
    ST_PUT,
    ST_FILL,
    ST_PACK,
    ST_DONE
  } rdc_state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic div10;
    logic acc_step;
    logic val_load;
    logic dig_put;
    logic sat;
    logic pack_step;
    logic out_load;
  } rdc_cmd_t;

  typedef struct packed {
    logic quot_zero;
  } rdc_sts_t;

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    if (b < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (b > RADIX_TEN) begin
      r = RADIX_TEN;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ===== rtl/radix_digit_converter.sv =====
// Top level of the radix digit converter: config registers, output register, ctrl and datapath.
//
//  channel | signals                                  | beat
//  in      | in_valid, in_ready, digit_number         | one number to convert
//  out     | out_valid, out_ready, converted, overflow| one packed result per input
//  cfg     | cfg_we, cfg_index, cfg_data              | one register write, no wait
//
// Each item divides its input by ten, one digit at a time, up to the highest nonzero digit
// (at most min(IN_DIGITS,10)) and sums those digits in base_in; it then divides by base_out
// to store up to OUT_DIGITS output digits, saturates them on overflow and packs all OUT_DIGITS.
// Both kinds of division use the shared long divider, 7 quotient bits a cycle.
// One item is in flight at a time; in_ready returns in the cycle after the load while a
// result may still wait in the output register. Synchronous reset sets base_in to 10
// and base_out to 2.
module radix_digit_converter import rdc_pkg::*; #(
  parameter int IN_DIGITS  = 9,
  parameter int OUT_DIGITS = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   digit_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  converted,
  output logic              overflow,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_data
);

  localparam int LANE_W = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;

  logic [BASE_W-1:0] base_in;
  logic [BASE_W-1:0] base_out;
  logic [BASE_W-1:0] rin;
  logic [BASE_W-1:0] rout;
  rdc_cmd_t          cmd;
  rdc_sts_t          sts;
  logic [LANE_W-1:0] lane;
  logic [OUT_W-1:0]  pack_val;
  logic              ovf;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_in  <= BASE_IN_RESET;
      base_out <= BASE_OUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_IN:  base_in  <= cfg_data;
        REG_BASE_OUT: base_out <= cfg_data;
      endcase
    end
  end

  assign rin      = clamp_base(base_in);
  assign rout     = clamp_base(base_out);
  assign out_free = !out_valid || out_ready;

  rdc_ctrl #(
    .IN_DIGITS  (IN_DIGITS),
    .OUT_DIGITS (OUT_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .lane     (lane)
  );

  rdc_dp #(
    .OUT_DIGITS (OUT_DIGITS)
  ) u_dp (
    .clk          (clk),
    .digit_number (digit_number),
    .rin          (rin),
    .rout         (rout),
    .cmd          (cmd),
    .lane         (lane),
    .sts          (sts),
    .pack_val     (pack_val),
    .ovf          (ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      converted <= pack_val;
      overflow  <= ovf;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !cmd.out_load)
    else $error("result beat overwritten before it was taken");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input beat taken while one is in work");

  a_sat_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> converted != '0)
    else $error("saturated result reads as zero");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid rose without a result load");

endmodule

// ===== rtl/rdc_ctrl.sv =====
// Sequencing state machine for the radix digit converter.
module rdc_ctrl import rdc_pkg::*; #(
  parameter int IN_DIGITS  = 9,
  parameter int OUT_DIGITS = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  rdc_sts_t            sts,
  output rdc_cmd_t            cmd,
  output logic [((OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1)-1:0] lane
);

  localparam int MAX_D  = (IN_DIGITS > OUT_DIGITS) ? IN_DIGITS : OUT_DIGITS;
  localparam int CNT_W  = $clog2(MAX_D + 1);
  localparam int LANE_W = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;

  localparam logic [CHUNK_CNT_W-1:0] CHUNK_LAST = CHUNK_CNT_W'(CHUNKS - 1);
  localparam logic [CNT_W-1:0]       IN_LAST    = CNT_W'(IN_DIGITS - 1);
  localparam logic [CNT_W-1:0]       OUT_LAST   = CNT_W'(OUT_DIGITS - 1);

  rdc_state_t             state, state_next;
  logic [CHUNK_CNT_W-1:0] chunk, chunk_next;
  logic [CNT_W-1:0]       cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chunk <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    chunk_next = chunk;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          chunk_next = '0;
          cnt_next   = '0;
          state_next = ST_DIV_IN;
        end
      end
      ST_DIV_IN: begin
        cmd.div_step = 1'b1;
        cmd.div10    = 1'b1;
        if (chunk == CHUNK_LAST) begin
          chunk_next = '0;
          state_next = ST_ACC;
        end else begin
          chunk_next = chunk + CHUNK_CNT_W'(1);
        end
      end
      ST_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.quot_zero || cnt == IN_LAST) begin
          cnt_next   = '0;
          state_next = ST_VAL;
        end else begin
          cnt_next   = cnt + CNT_W'(1);
          state_next = ST_DIV_IN;
        end
      end
      ST_VAL: begin
        cmd.val_load = 1'b1;
        state_next   = ST_DIV_OUT;
      end
      ST_DIV_OUT: begin
        cmd.div_step = 1'b1;
        if (chunk == CHUNK_LAST) begin
          chunk_next = '0;
          state_next = ST_PUT;
        end else begin
          chunk_next = chunk + CHUNK_CNT_W'(1);
        end
      end
      ST_PUT: begin
        cmd.dig_put = 1'b1;
        if (sts.quot_zero) begin
          cnt_next   = '0;
          state_next = ST_PACK;
        end else if (cnt == OUT_LAST) begin
          state_next = ST_FILL;
        end else begin
          cnt_next   = cnt + CNT_W'(1);
          state_next = ST_DIV_OUT;
        end
      end
      ST_FILL: begin
        cmd.sat    = 1'b1;
        cnt_next   = '0;
        state_next = ST_PACK;
      end
      ST_PACK: begin
        cmd.pack_step = 1'b1;
        if (cnt == OUT_LAST) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign lane = cnt[LANE_W-1:0];

endmodule

// ===== rtl/rdc_dp.sv =====
// Datapath: shared small-divisor long divider, accumulator, digit lanes and packer.
module rdc_dp import rdc_pkg::*; #(
  parameter int OUT_DIGITS = 19
) (
  input  logic                clk,
  input  logic [IN_W-1:0]     digit_number,
  input  logic [BASE_W-1:0]   rin,
  input  logic [BASE_W-1:0]   rout,
  input  rdc_cmd_t            cmd,
  input  logic [((OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1)-1:0] lane,
  output rdc_sts_t            sts,
  output logic [OUT_W-1:0]    pack_val,
  output logic                ovf
);

  logic [VAL_W-1:0]        quot;
  logic [BASE_W-1:0]       rem;
  logic [VAL_W-1:0]        acc;
  logic [VAL_W-1:0]        wgt;
  logic [BASE_W-1:0]       dig [OUT_DIGITS];

  logic [VAL_W-1:0]        div_quot;
  logic [BASE_W-1:0]       div_rem;
  logic [VAL_W+BASE_W-1:0] term_acc;
  logic [VAL_W+BASE_W-1:0] term_wgt;
  logic [OUT_W-1:0]        pack_next;

  always_comb begin
    logic [BASE_W:0]   t;
    logic [BASE_W-1:0] r;
    logic [BASE_W-1:0] dvs;
    logic [CHUNK-1:0]  qb;
    dvs = cmd.div10 ? RADIX_TEN : rout;
    r   = rem;
    qb  = '0;
    for (int j = 0; j < CHUNK; j++) begin
      t = {r, quot[VAL_W-1-j]};
      if (t >= {1'b0, dvs}) begin
        t              = t - {1'b0, dvs};
        qb[CHUNK-1-j] = 1'b1;
      end
      r = t[BASE_W-1:0];
    end
    div_quot = {quot[VAL_W-CHUNK-1:0], qb};
    div_rem  = r;
  end

  assign term_acc  = {{BASE_W{1'b0}}, wgt} * {{VAL_W{1'b0}}, rem};
  assign term_wgt  = {{BASE_W{1'b0}}, wgt} * {{VAL_W{1'b0}}, rin};
  assign pack_next = (pack_val << 3) + (pack_val << 1) + OUT_W'(dig[OUT_DIGITS-1]);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quot     <= VAL_W'(digit_number);
      rem      <= '0;
      acc      <= '0;
      wgt      <= VAL_W'(1);
      pack_val <= '0;
      ovf      <= 1'b0;
      for (int i = 0; i < OUT_DIGITS; i++) begin
        dig[i] <= '0;
      end
    end else if (cmd.div_step) begin
      quot <= div_quot;
      rem  <= div_rem;
    end else if (cmd.acc_step) begin
      acc <= acc + term_acc[VAL_W-1:0];
      wgt <= term_wgt[VAL_W-1:0];
      rem <= '0;
    end else if (cmd.val_load) begin
      quot <= acc;
      rem  <= '0;
    end else if (cmd.dig_put) begin
      dig[lane] <= rem;
      rem       <= '0;
    end else if (cmd.sat) begin
      ovf <= 1'b1;
      for (int i = 0; i < OUT_DIGITS; i++) begin
        dig[i] <= rout - BASE_W'(1);
      end
    end else if (cmd.pack_step) begin
      pack_val <= pack_next;
      dig[0]   <= '0;
      for (int i = 1; i < OUT_DIGITS; i++) begin
        dig[i] <= dig[i-1];
      end
    end
  end

  assign sts.quot_zero = (quot == '0);

endmodule
